// ----- design/real_to_complex_nco_mixer_defines.svh -----
// Assertion macros shared by the mixer RTL.
`ifndef REAL_TO_COMPLEX_NCO_MIXER_DEFINES_SVH
`define REAL_TO_COMPLEX_NCO_MIXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RCNM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RCNM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rcnm_pkg.sv -----
// Shared types, constants and the sine table generator for the NCO mixer.
`timescale 1ns / 1ps

package rcnm_pkg;

  localparam int TRIG_BITS     = 16;  // Q1.15 oscillator value
  localparam int TRIG_MAG_BITS = 15;
  localparam int TRIG_FRAC     = 15;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] HALF_Q30    = 64'd1 << 29;
  localparam logic [63:0] TRIG_MAX    = 64'd32767;

  // (2n)(2n+1) for the Taylor terms n = 1..7
  localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_START_PHASE = 2'd1,
    CFG_CONJ_MODE   = 2'd2
  } cfg_idx_t;

  typedef logic [TRIG_MAG_BITS-1:0] trig_mag_t;
  typedef logic signed [TRIG_BITS-1:0] trig_t;

  typedef struct packed {
    logic sin_neg;
    logic cos_neg;
  } quad_sign_t;

  // One quarter-wave entry: sin(k/2^abits * pi/2) in Q1.15, elaboration only.
  function automatic trig_mag_t sine_entry(input int unsigned k, input int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * TRIG_MAX + HALF_Q30) >> 30;
    if (v > TRIG_MAX) begin
      v = TRIG_MAX;
    end
    return v[TRIG_MAG_BITS-1:0];
  endfunction

endpackage

// ----- design/rcnm_phase.sv -----
// Phase accumulator and quarter-wave address decode, registered per item.
`timescale 1ns / 1ps

module rcnm_phase #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       first,
  input  logic [PHASE_BITS-1:0]      phase_step,
  input  logic [PHASE_BITS-1:0]      start_phase,
  input  logic                       conj,
  output logic [TABLE_ADDR_BITS:0]   sin_addr_r,
  output logic [TABLE_ADDR_BITS:0]   cos_addr_r,
  output rcnm_pkg::quad_sign_t       sign_r
);

  localparam int ADDR_BITS = TABLE_ADDR_BITS + 1;
  localparam logic [ADDR_BITS-1:0] TBL_TOP = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

  logic [PHASE_BITS-1:0]        acc_r;
  logic [PHASE_BITS-1:0]        acc_nxt;
  logic [PHASE_BITS-1:0]        ph;
  logic [TABLE_ADDR_BITS+1:0]   top;
  logic [1:0]                   quad;
  logic [1:0]                   quad_cos;
  logic [TABLE_ADDR_BITS-1:0]   idx;
  logic [ADDR_BITS-1:0]         idx_fwd;
  logic [ADDR_BITS-1:0]         idx_rev;
  logic [ADDR_BITS-1:0]         sin_addr_nxt;
  logic [ADDR_BITS-1:0]         cos_addr_nxt;
  rcnm_pkg::quad_sign_t         sign_nxt;

  always_comb begin
    ph           = first ? start_phase : acc_r;
    acc_nxt      = ph + phase_step;
    top          = ph[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
    quad         = top[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
    idx          = top[TABLE_ADDR_BITS-1:0];
    quad_cos     = quad + 2'd1;
    idx_fwd      = {1'b0, idx};
    idx_rev      = TBL_TOP - idx_fwd;
    sin_addr_nxt = quad[0] ? idx_rev : idx_fwd;
    cos_addr_nxt = quad_cos[0] ? idx_rev : idx_fwd;
    sign_nxt.sin_neg = quad[1] ^ conj;
    sign_nxt.cos_neg = quad_cos[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (load) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sin_addr_r <= sin_addr_nxt;
      cos_addr_r <= cos_addr_nxt;
      sign_r     <= sign_nxt;
    end
  end

endmodule

// ----- design/rcnm_sine_rom.sv -----
// Dual-read quarter-wave sine ROM with registered, sign-applied outputs.
`timescale 1ns / 1ps

module rcnm_sine_rom #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [TABLE_ADDR_BITS:0]  sin_addr,
  input  logic [TABLE_ADDR_BITS:0]  cos_addr,
  input  rcnm_pkg::quad_sign_t      sign,
  output rcnm_pkg::trig_t           sin_r,
  output rcnm_pkg::trig_t           cos_r
);

  localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;

  typedef rcnm_pkg::trig_mag_t rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = rcnm_pkg::sine_entry(k, TABLE_ADDR_BITS);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  rcnm_pkg::trig_t sin_mag;
  rcnm_pkg::trig_t cos_mag;

  always_comb begin
    sin_mag = signed'({1'b0, ROM[sin_addr]});
    cos_mag = signed'({1'b0, ROM[cos_addr]});
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sin_r <= sign.sin_neg ? -sin_mag : sin_mag;
      cos_r <= sign.cos_neg ? -cos_mag : cos_mag;
    end
  end

endmodule

// ----- design/rcnm_mix.sv -----
// Sample by oscillator multiply, round half up and saturate, registered.
`timescale 1ns / 1ps

module rcnm_mix #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  rcnm_pkg::trig_t               cos_val,
  input  rcnm_pkg::trig_t               sin_val,
  output logic signed [SAMPLE_BITS-1:0] in_phase_r,
  output logic signed [SAMPLE_BITS-1:0] quadrature_r
);

  localparam int PROD_BITS = SAMPLE_BITS + rcnm_pkg::TRIG_BITS;
  localparam int RND_BITS  = PROD_BITS + 1;
  localparam logic signed [RND_BITS-1:0] ROUND_HALF =
    RND_BITS'(1) << (rcnm_pkg::TRIG_FRAC - 1);
  localparam logic signed [RND_BITS-1:0] SAT_HI =
    RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_BITS-1:0] SAT_LO = -SAT_HI - RND_BITS'(1);

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [RND_BITS-1:0] s;
    logic signed [RND_BITS-1:0] q;
    s = RND_BITS'(p) + ROUND_HALF;
    q = s >>> rcnm_pkg::TRIG_FRAC;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[SAMPLE_BITS-1:0];
  endfunction

  logic signed [PROD_BITS-1:0] prod_i;
  logic signed [PROD_BITS-1:0] prod_q;

  always_comb begin
    prod_i = PROD_BITS'(sample) * PROD_BITS'(cos_val);
    prod_q = PROD_BITS'(sample) * PROD_BITS'(sin_val);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_phase_r   <= round_sat(prod_i);
      quadrature_r <= round_sat(prod_q);
    end
  end

endmodule

// ----- design/real_to_complex_nco_mixer.sv -----
// Top level: real to complex NCO quadrature mixer, three-stage pipeline.
//
//   channel | ports                          | carries
//   --------+--------------------------------+----------------------------------
//   input   | in_tvalid/in_tready            | tdata: sample; tuser: first;
//           |                                | tlast: last_in
//   result  | out_tvalid/out_tready          | tdata: in_phase, quadrature;
//           |                                | tlast: last_out
//   config  | cfg_valid/cfg_ready            | cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while out_tready stays high; each item passes the address
// register, sine ROM read register and multiply/round/saturate output register.
// Synchronous active-low reset clears the phase, config registers and stage valids.
// Each stage holds its item while the next is full; with out_tready low the
// pipe takes up to three items, then in_tready drops.
`timescale 1ns / 1ps
`include "real_to_complex_nco_mixer_defines.svh"

module real_to_complex_nco_mixer #(
  parameter int SAMPLE_BITS       = 16,
  parameter int PHASE_BITS        = 32,
  parameter int TABLE_ADDR_BITS   = 10,
  localparam int IN_DATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_BITS    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_DATA_BITS-1:0]           in_tdata,   // sample
  input  logic                              in_tuser,   // first
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_DATA_BITS-1:0]          out_tdata,  // in_phase, quadrature
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcnm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PHASE_BITS-1:0]             cfg_data
);

  logic [PHASE_BITS-1:0] phase_step_r;
  logic [PHASE_BITS-1:0] start_phase_r;
  logic                  conj_r;

  logic v0_r;
  logic v1_r;
  logic v2_r;
  logic rdy0;
  logic rdy1;
  logic rdy2;
  logic in_fire;

  logic signed [SAMPLE_BITS-1:0] sample0_r;
  logic signed [SAMPLE_BITS-1:0] sample1_r;
  logic                          last0_r;
  logic                          last1_r;
  logic                          last2_r;

  logic [TABLE_ADDR_BITS:0]      sin_addr;
  logic [TABLE_ADDR_BITS:0]      cos_addr;
  rcnm_pkg::quad_sign_t          sign;
  rcnm_pkg::trig_t               sin_val;
  rcnm_pkg::trig_t               cos_val;
  logic signed [SAMPLE_BITS-1:0] in_phase;
  logic signed [SAMPLE_BITS-1:0] quadrature;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= '0;
      start_phase_r <= '0;
      conj_r        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rcnm_pkg::cfg_idx_t'(cfg_index))
        rcnm_pkg::CFG_PHASE_STEP:  phase_step_r  <= cfg_data;
        rcnm_pkg::CFG_START_PHASE: start_phase_r <= cfg_data;
        rcnm_pkg::CFG_CONJ_MODE:   conj_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  always_comb begin
    rdy2    = !v2_r || out_tready;
    rdy1    = !v1_r || rdy2;
    rdy0    = !v0_r || rdy1;
    in_fire = in_tvalid && rdy0;
  end

  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_fire;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample0_r <= in_tdata[SAMPLE_BITS-1:0];
      last0_r   <= in_tlast;
    end
    if (rdy1 && v0_r) begin
      sample1_r <= sample0_r;
      last1_r   <= last0_r;
    end
    if (rdy2 && v1_r) begin
      last2_r <= last1_r;
    end
  end

  rcnm_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_fire),
    .first       (in_tuser),
    .phase_step  (phase_step_r),
    .start_phase (start_phase_r),
    .conj        (conj_r),
    .sin_addr_r  (sin_addr),
    .cos_addr_r  (cos_addr),
    .sign_r      (sign)
  );

  rcnm_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk      (clk),
    .rd_en    (rdy1 && v0_r),
    .sin_addr (sin_addr),
    .cos_addr (cos_addr),
    .sign     (sign),
    .sin_r    (sin_val),
    .cos_r    (cos_val)
  );

  rcnm_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk          (clk),
    .en           (rdy2 && v1_r),
    .sample       (sample1_r),
    .cos_val      (cos_val),
    .sin_val      (sin_val),
    .in_phase_r   (in_phase),
    .quadrature_r (quadrature)
  );

  assign out_tvalid = v2_r;
  assign out_tdata  = OUT_DATA_BITS'({quadrature, in_phase});
  assign out_tlast  = last2_r;

  `RCNM_ASSERT_NOW(a_full_stall, v0_r && v1_r && v2_r && !out_tready, !in_tready, "input taken into a full pipe")
  `RCNM_ASSERT_NXT(a_fire_fills, in_fire, v0_r, "accepted item missing from first stage")
  `RCNM_ASSERT_NXT(a_mid_hold, v1_r && !rdy2, v1_r, "item lost from ROM stage while stalled")
  `RCNM_ASSERT_NXT(a_no_repeat, out_tvalid && out_tready && !v1_r, !out_tvalid, "result repeated after hand-over")

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the real to complex NCO quadrature mixer.
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_W   = 16;
  localparam int TBL_LEN    = 1024;
  localparam int IDLE_LIMIT = 1000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t in_phase;
    sample_t quadrature;
    logic    last_out;
  } mix_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata = '0;   // sample
  logic                   in_tuser = 1'b0; // first
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [31:0]            out_tdata;       // in_phase, quadrature
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [rcnm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  real_to_complex_nco_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Oscillator model state
  sample_t     osc_table [0:TBL_LEN];
  logic [31:0] nco_phase = '0;
  logic [31:0] step_reg = '0;
  logic [31:0] start_reg = '0;
  logic        conj_reg = 1'b0;

  mix_result_t pending_mix [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          out_hold = 0;
  bit          in_idle_off = 1'b0;
  bit          out_stall_off = 1'b0;

  function automatic void build_osc_table();
    logic [63:0] ang, ang2, term, acc, v;
    for (int k = 0; k <= TBL_LEN; k++) begin
      ang  = (64'(k) * rcnm_pkg::HALF_PI_Q30) >> 10;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = ang;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      osc_table[k] = sample_t'(v[15:0]);
    end
  endfunction

  function automatic sample_t osc_value(input logic [1:0] quad, input logic [9:0] idx);
    sample_t v;
    v = quad[0] ? osc_table[TBL_LEN - int'(idx)] : osc_table[int'(idx)];
    return quad[1] ? -v : v;
  endfunction

  function automatic sample_t round_sat(input sample_t s, input sample_t t);
    longint p;
    p = (longint'(s) * longint'(t) + 64'sd16384) >>> 15;
    if (p > 32767) begin
      p = 32767;
    end else if (p < -32768) begin
      p = -32768;
    end
    return sample_t'(p[15:0]);
  endfunction

  function automatic mix_result_t predict_mix(input sample_t s, input logic is_first,
                                              input logic is_last);
    mix_result_t r;
    logic [11:0] top;
    sample_t     sin_v, cos_v;
    if (is_first) begin
      nco_phase = start_reg;
    end
    top   = nco_phase[31:20];
    sin_v = osc_value(top[11:10], top[9:0]);
    cos_v = osc_value(top[11:10] + 2'd1, top[9:0]);
    if (conj_reg) begin
      sin_v = -sin_v;
    end
    r.in_phase   = round_sat(s, cos_v);
    r.quadrature = round_sat(s, sin_v);
    r.last_out   = is_last;
    nco_phase    = nco_phase + step_reg;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 16'sh7FFF;
    end else if (r == 1) begin
      return 16'sh8000;
    end else if (r == 2) begin
      return sample_t'($urandom_range(0, 15) - 8);
    end
    return sample_t'($urandom);
  endfunction

  // Result side: random back-pressure and checking
  always @(posedge clk) begin
    mix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mix.size() == 0) begin
        $error("result with no item outstanding: tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_mix.pop_front();
        if (sample_t'(out_tdata[15:0]) !== want.in_phase) begin
          $error("in_phase: expected %0d, got %0d", want.in_phase,
                 sample_t'(out_tdata[15:0]));
          mismatches++;
        end
        if (sample_t'(out_tdata[31:16]) !== want.quadrature) begin
          $error("quadrature: expected %0d, got %0d", want.quadrature,
                 sample_t'(out_tdata[31:16]));
          mismatches++;
        end
        if (out_tlast !== want.last_out) begin
          $error("last_out: expected %0d, got %0d", want.last_out, out_tlast);
          mismatches++;
        end
      end
    end
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (!out_stall_off && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      out_hold <= gap_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_sample(input sample_t s, input logic is_first, input logic is_last);
    int gap;
    gap = 0;
    if (!in_idle_off && $urandom_range(0, 99) < 30) begin
      gap = gap_len();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= is_first;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_mix.push_back(predict_mix(s, is_first, is_last));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input rcnm_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rcnm_pkg::CFG_PHASE_STEP:  step_reg = val;
      rcnm_pkg::CFG_START_PHASE: start_reg = val;
      rcnm_pkg::CFG_CONJ_MODE:   conj_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_nco(input logic [31:0] step, input logic [31:0] start,
                         input logic [31:0] conj);
    write_reg(rcnm_pkg::CFG_PHASE_STEP, step);
    write_reg(rcnm_pkg::CFG_START_PHASE, start);
    write_reg(rcnm_pkg::CFG_CONJ_MODE, conj);
    cfg_valid <= 1'b0;
  endtask

  // Reset values: phase zero, cosine at full scale, sine zero
  task automatic test_reset_defaults();
    push_sample(16'sh7FFF, 1'b0, 1'b0);
    push_sample(16'sh8000, 1'b0, 1'b0);
    push_sample(16'sh0000, 1'b1, 1'b0);
    push_sample(16'sh0001, 1'b0, 1'b0);
    push_sample(16'shFFFF, 1'b1, 1'b1);
    wait_drained();
  endtask

  // Quarter- and eighth-turn steps through all quadrants, reload mid-run, conjugate on and off
  task automatic test_quarter_turns();
    set_nco(32'h4000_0000, 32'hC000_0000, 32'h0);
    push_sample(16'sh7FFF, 1'b1, 1'b0);
    push_sample(16'sh8000, 1'b0, 1'b0);
    push_sample(16'sh7FFF, 1'b0, 1'b0);
    push_sample(16'sh8000, 1'b1, 1'b0);
    push_sample(16'sh4000, 1'b0, 1'b1);
    wait_drained();
    set_nco(32'h2000_0000, 32'h1000_0000, 32'h1);
    for (int j = 0; j < 6; j++) begin
      push_sample(j[0] ? 16'sh8000 : 16'sh7FFF, j == 0, j == 5);
    end
    wait_drained();
  endtask

  // Table edges, quadrant boundaries and wrap of the accumulator
  task automatic test_phase_wrap();
    set_nco(32'h0010_0000, 32'h3FF0_0000, 32'hFFFF_FFFE);
    for (int j = 0; j < 4; j++) begin
      push_sample(16'sh7FFF, j == 0, j == 3);
    end
    wait_drained();
    set_nco(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    for (int j = 0; j < 4; j++) begin
      push_sample(16'sh8000, j == 0, 1'b0);
    end
    wait_drained();
  endtask

  // Blocks of random samples under several oscillator settings
  task automatic test_random_stream();
    logic [31:0] st, sp, cj;
    int          blk, left;
    bit          tidy;
    for (int setting = 0; setting < 6; setting++) begin
      case (setting)
        0: begin st = '0; sp = '1; cj = 32'hFFFF_FFFF; end
        1: begin st = '1; sp = '0; cj = 32'hFFFF_FFFE; end
        2: begin st = $urandom_range(1, 32'h0010_0000); sp = $urandom; cj = $urandom; end
        default: begin st = $urandom; sp = $urandom; cj = $urandom; end
      endcase
      set_nco(st, sp, cj);
      left = 75;
      while (left > 0) begin
        blk = $urandom_range(1, 16);
        if (blk > left) begin
          blk = left;
        end
        in_idle_off   = ($urandom_range(0, 4) == 0);
        out_stall_off = ($urandom_range(0, 4) == 0);
        tidy          = ($urandom_range(0, 99) < 85);
        for (int j = 0; j < blk; j++) begin
          if (tidy) begin
            push_sample(rand_sample(), j == 0, j == blk - 1);
          end else begin
            push_sample(rand_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        left -= blk;
      end
      wait_drained();
    end
  endtask

  initial begin
    build_osc_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_quarter_turns();
    test_phase_wrap();
    test_random_stream();
    out_stall_off = 1'b1;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_mix.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
